>>> hw/rtl/square_piece_list_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the square piece list table
// Shared property forms used by the controller and the datapath.
// ---------------------------------------------------------------------------
`ifndef SQUARE_PIECE_LIST_TABLE_MACROS_SVH
`define SQUARE_PIECE_LIST_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPL_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("square piece list table: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPL_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("square piece list table: next-cycle check failed");

`endif

>>> hw/rtl/spl_pkg.sv
// ---------------------------------------------------------------------------
// spl_pkg
// Types and constants shared by the square piece list table modules.
// ---------------------------------------------------------------------------
`default_nettype none

package spl_pkg;

    localparam int MAX_ENTRIES_DEFAULT = 16;
    localparam int SQ_W                = 6;
    localparam int NUM_SQUARES         = 64;
    localparam int IDX_W               = 4;
    localparam int PIECE_COUNT_W       = 5;
    localparam int ACTION_W            = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_MOVE   = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture an accepted item
        logic lookup;  // read both memories
        logic commit;  // write memories, update count, load result
    } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/spl_ctrl.sv
// ---------------------------------------------------------------------------
// spl_ctrl
// Sequencer for the lookup and commit phases and owner of the result valid.
// ---------------------------------------------------------------------------
`default_nettype none

`include "square_piece_list_table_macros.svh"

module spl_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    output spl_pkg::cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !out_stall;

    // A new item may enter while the previous one commits, if the result
    // register is free.
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_COMMIT) && out_free));
    assign accept   = in_valid && !in_stall;

    assign cmd.load   = accept;
    assign cmd.lookup = (state_reg == ST_LOOKUP);
    assign cmd.commit = (state_reg == ST_COMMIT) && out_free;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `SPL_ASSERT_NEXT(a_accept_to_lookup, accept, state_reg == ST_LOOKUP)
    `SPL_ASSERT_NEXT(a_lookup_to_commit, state_reg == ST_LOOKUP, state_reg == ST_COMMIT)
    `SPL_ASSERT_NEXT(a_commit_gives_result, cmd.commit, out_valid_reg)
    `SPL_ASSERT_SAME(a_no_overwrite, cmd.commit, !out_valid_reg || !out_stall)

endmodule

`default_nettype wire

>>> hw/rtl/spl_datapath.sv
// ---------------------------------------------------------------------------
// spl_datapath
// Square list and square-to-slot memories, entry count and result registers.
// ---------------------------------------------------------------------------
`default_nettype none

`include "square_piece_list_table_macros.svh"

module spl_datapath #(
    parameter int MAX_ENTRIES = spl_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire spl_pkg::cmd_t                      cmd,
    input  wire logic [spl_pkg::ACTION_W-1:0]       action,
    input  wire logic [spl_pkg::SQ_W-1:0]           square_a,
    input  wire logic [spl_pkg::SQ_W-1:0]           square_b,
    input  wire logic [spl_pkg::IDX_W-1:0]          entry_index,
    output logic      [spl_pkg::PIECE_COUNT_W-1:0]  piece_count,
    output logic      [spl_pkg::SQ_W-1:0]           entry_square,
    output logic                                    fault
);

    localparam int SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = 8;
    localparam int SQ_W   = spl_pkg::SQ_W;

    logic [SQ_W-1:0]   list_mem [MAX_ENTRIES];
    logic [SLOT_W-1:0] map_mem  [spl_pkg::NUM_SQUARES];

    spl_pkg::action_t          act_reg;
    logic [SQ_W-1:0]           sqa_reg;
    logic [SQ_W-1:0]           sqb_reg;
    logic [spl_pkg::IDX_W-1:0] idx_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] map_rd_reg;
    logic [SQ_W-1:0]   list_rd_reg;

    logic [spl_pkg::PIECE_COUNT_W-1:0] piece_count_reg;
    logic [SQ_W-1:0]                   entry_square_reg, entry_square_next;
    logic                              fault_reg, fault_next;

    logic [SQ_W-1:0]   map_raddr;
    logic [SLOT_W-1:0] list_raddr;
    logic              list_we, map_we;
    logic [SLOT_W-1:0] list_waddr;
    logic [SQ_W-1:0]   list_wdata;
    logic [SQ_W-1:0]   map_waddr;
    logic [SLOT_W-1:0] map_wdata;
    logic              full, empty, idx_ok;
    logic [CNT_W-1:0]  last_idx;

    assign full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign empty    = (count_reg == '0);
    assign idx_ok   = (CMP_W'(idx_reg) < CMP_W'(count_reg));
    assign last_idx = empty ? '0 : (count_reg - CNT_W'(1));

    // Lookup phase: the map is read for the named square, the list at the
    // requested position for a read and at its last entry otherwise.
    always_comb
    begin
        map_raddr  = (act_reg == spl_pkg::ACT_REMOVE) ? sqb_reg : sqa_reg;
        list_raddr = (act_reg == spl_pkg::ACT_READ) ? SLOT_W'(idx_reg) : SLOT_W'(last_idx);
    end

    always_comb
    begin
        list_we           = 1'b0;
        map_we            = 1'b0;
        list_waddr        = map_rd_reg;
        list_wdata        = sqb_reg;
        map_waddr         = sqb_reg;
        map_wdata         = map_rd_reg;
        count_next        = count_reg;
        entry_square_next = '0;
        fault_next        = 1'b0;
        unique case (act_reg)
            spl_pkg::ACT_ADD:
            begin
                fault_next = full;
                if (!full)
                begin
                    list_we    = 1'b1;
                    map_we     = 1'b1;
                    list_waddr = SLOT_W'(count_reg);
                    list_wdata = sqa_reg;
                    map_waddr  = sqa_reg;
                    map_wdata  = SLOT_W'(count_reg);
                    count_next = count_reg + CNT_W'(1);
                end
            end
            spl_pkg::ACT_REMOVE:
            begin
                fault_next = empty;
                if (!empty)
                begin
                    // The last entry fills the hole left by the removed square.
                    list_we    = 1'b1;
                    map_we     = 1'b1;
                    list_waddr = map_rd_reg;
                    list_wdata = list_rd_reg;
                    map_waddr  = list_rd_reg;
                    map_wdata  = map_rd_reg;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            spl_pkg::ACT_MOVE:
            begin
                list_we = 1'b1;
                map_we  = 1'b1;
            end
            spl_pkg::ACT_READ:
            begin
                entry_square_next = idx_ok ? list_rd_reg : '0;
            end
            default:
            begin
                fault_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= spl_pkg::action_t'(action);
            sqa_reg <= square_a;
            sqb_reg <= square_b;
            idx_reg <= entry_index;
        end
        if (cmd.lookup)
        begin
            map_rd_reg  <= map_mem[map_raddr];
            list_rd_reg <= list_mem[list_raddr];
        end
        if (cmd.commit)
        begin
            piece_count_reg  <= spl_pkg::PIECE_COUNT_W'(count_next);
            entry_square_reg <= entry_square_next;
            fault_reg        <= fault_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    assign piece_count  = piece_count_reg;
    assign entry_square = entry_square_reg;
    assign fault        = fault_reg;

    `SPL_ASSERT_SAME(a_count_bound, 1'b1, CMP_W'(count_reg) <= CMP_W'(MAX_ENTRIES))
    `SPL_ASSERT_NEXT(a_fault_keeps_count, cmd.commit && fault_next, $stable(count_reg))

endmodule

`default_nettype wire

>>> hw/rtl/square_piece_list_table.sv
// ---------------------------------------------------------------------------
// square_piece_list_table
// Dense list of occupied squares with a square-to-slot map and swap-remove.
// ---------------------------------------------------------------------------
// Each item passes through a lookup state that reads the square-to-slot
// map and the square list together, then a commit state that writes both
// memories and the count and loads the result register. The next item is
// accepted during the commit state if the result register is free; the
// dependent map read and list write of a remove stay in separate states.
// The result register holds one finished item; while it is stalled, the
// item in work waits in its commit state. Both memories start undefined;
// remove or move on a square that was never added returns an undefined slot.
`default_nettype none

module square_piece_list_table #(
    parameter int MAX_ENTRIES = spl_pkg::MAX_ENTRIES_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [spl_pkg::ACTION_W-1:0]       action,
    input  wire logic [spl_pkg::SQ_W-1:0]           square_a,
    input  wire logic [spl_pkg::SQ_W-1:0]           square_b,
    input  wire logic [spl_pkg::IDX_W-1:0]          entry_index,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic      [spl_pkg::PIECE_COUNT_W-1:0]  piece_count,
    output logic      [spl_pkg::SQ_W-1:0]           entry_square,
    output logic                                    fault
);

    spl_pkg::cmd_t cmd;

    spl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    spl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .square_a     (square_a),
        .square_b     (square_b),
        .entry_index  (entry_index),
        .piece_count  (piece_count),
        .entry_square (entry_square),
        .fault        (fault)
    );

endmodule

`default_nettype wire

>>> test/square_piece_list_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// square_piece_list_table_tb
// Drives add, remove, move and read operations into the piece list table and
// checks every result against a predictor of the dense list and its map, or against a directed row's expected value.
// ---------------------------------------------------------------------------
module square_piece_list_table_tb;

    localparam int LIST_DEPTH  = spl_pkg::MAX_ENTRIES_DEFAULT;
    localparam int SQ_W        = spl_pkg::SQ_W;
    localparam int IDX_W       = spl_pkg::IDX_W;
    localparam int ACTION_W    = spl_pkg::ACTION_W;
    localparam int NUM_SQUARES = spl_pkg::NUM_SQUARES;
    localparam int PIECE_COUNT_W = spl_pkg::PIECE_COUNT_W;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [PIECE_COUNT_W-1:0] count;
        logic [SQ_W-1:0]          square;
        logic                     fault;
    } board_result_t;

    // One directed row; rows with reps above one add squares at a stride of four.
    typedef struct packed {
        spl_pkg::action_t         act;
        logic [SQ_W-1:0]          sq_a;
        logic [SQ_W-1:0]          sq_b;
        logic [IDX_W-1:0]         idx;
        logic [4:0]               reps;
        logic                     exact;
        logic [PIECE_COUNT_W-1:0] want_count;
        logic [SQ_W-1:0]          want_square;
        logic                     want_fault;
    } plan_row_t;

    logic                     clk;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [ACTION_W-1:0]      action = '0;
    logic [SQ_W-1:0]          square_a = '0;
    logic [SQ_W-1:0]          square_b = '0;
    logic [IDX_W-1:0]         entry_index = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [PIECE_COUNT_W-1:0] piece_count;
    logic [SQ_W-1:0]          entry_square;
    logic                     fault;

    // Predictor state.
    logic [SQ_W-1:0]          occupied_list [LIST_DEPTH];
    logic [IDX_W-1:0]         slot_of_square [NUM_SQUARES];
    logic                     slot_known [NUM_SQUARES];
    logic [PIECE_COUNT_W-1:0] occupied_count = '0;

    board_result_t            expected_results [$];
    plan_row_t                plan [17];
    int                       send_gap_pct = 0;
    int                       recv_stall_pct = 0;
    int                       hold_requests = 0;
    int                       hold_served = 0;
    int                       error_count = 0;
    int                       cycle_count = 0;
    int                       gap_by_phase [3] = '{17, 58, 0};
    int                       stall_by_phase [3] = '{58, 17, 0};

    square_piece_list_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .square_a     (square_a),
        .square_b     (square_b),
        .entry_index  (entry_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .piece_count  (piece_count),
        .entry_square (entry_square),
        .fault        (fault)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                 want);
        error_count++;
    endtask

    function automatic board_result_t apply_board_op(input spl_pkg::action_t act,
                                                     input logic [SQ_W-1:0] sa,
                                                     input logic [SQ_W-1:0] sb,
                                                     input logic [IDX_W-1:0] ix);
        board_result_t    r;
        logic [IDX_W-1:0] slot;
        logic [SQ_W-1:0]  moved;
        r = '0;
        case (act)
            spl_pkg::ACT_ADD:
            begin
                if (occupied_count >= LIST_DEPTH)
                    r.fault = 1'b1;
                else
                begin
                    occupied_list[occupied_count[IDX_W-1:0]] = sa;
                    slot_of_square[sa] = occupied_count[IDX_W-1:0];
                    slot_known[sa] = 1'b1;
                    occupied_count = occupied_count + 1'b1;
                end
            end
            spl_pkg::ACT_REMOVE:
            begin
                if (occupied_count == 0)
                    r.fault = 1'b1;
                else
                begin
                    // Swap-remove: the last entry fills the slot of the removed square.
                    slot = slot_of_square[sb];
                    moved = occupied_list[occupied_count[IDX_W-1:0] - 1'b1];
                    occupied_list[slot] = moved;
                    slot_of_square[moved] = slot;
                    slot_known[moved] = 1'b1;
                    occupied_count = occupied_count - 1'b1;
                end
            end
            spl_pkg::ACT_MOVE:
            begin
                slot = slot_of_square[sa];
                occupied_list[slot] = sb;
                slot_of_square[sb] = slot;
                slot_known[sb] = 1'b1;
            end
            default:
            begin
                if (ix < occupied_count)
                    r.square = occupied_list[ix];
            end
        endcase
        r.count = occupied_count;
        return r;
    endfunction

    // A square whose map entry has been written, mostly one that is on the list now.
    function automatic logic [SQ_W-1:0] written_square();
        logic [SQ_W-1:0] sq;
        if (occupied_count != 0 && $urandom_range(99) < 75)
            return occupied_list[IDX_W'($urandom_range(occupied_count - 1))];
        sq = SQ_W'($urandom_range(NUM_SQUARES - 1));
        while (!slot_known[sq])
            sq = SQ_W'($urandom_range(NUM_SQUARES - 1));
        return sq;
    endfunction

    task automatic send_op(input spl_pkg::action_t act, input logic [SQ_W-1:0] sa,
                           input logic [SQ_W-1:0] sb, input logic [IDX_W-1:0] ix,
                           input logic exact, input board_result_t want);
        board_result_t predicted;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        square_a    <= sa;
        square_b    <= sb;
        entry_index <= ix;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        predicted = apply_board_op(act, sa, sb, ix);
        expected_results.push_back(exact ? want : predicted);
    endtask

    task automatic send_random_op();
        spl_pkg::action_t act;
        logic [SQ_W-1:0]  sa;
        logic [SQ_W-1:0]  sb;
        logic [IDX_W-1:0] ix;
        int               roll;
        roll = $urandom_range(99);
        sa = SQ_W'($urandom_range(NUM_SQUARES - 1));
        sb = SQ_W'($urandom_range(NUM_SQUARES - 1));
        ix = IDX_W'($urandom_range(LIST_DEPTH - 1));
        if (roll < 10)
            act = spl_pkg::action_t'($urandom_range(3));
        else if (roll < 46)
            act = spl_pkg::ACT_ADD;
        else if (roll < 78)
            act = spl_pkg::ACT_REMOVE;
        else if (roll < 88)
            act = spl_pkg::ACT_MOVE;
        else
            act = spl_pkg::ACT_READ;
        // Remove and move must only name squares whose map entry exists.
        if (act == spl_pkg::ACT_REMOVE)
            sb = written_square();
        else if (act == spl_pkg::ACT_MOVE)
            sa = written_square();
        send_op(act, sa, sb, ix, 1'b0, '0);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        board_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected, count", piece_count, -1);
            else
            begin
                want = expected_results.pop_front();
                if (piece_count !== want.count)
                    report_mismatch("piece_count", piece_count, want.count);
                if (entry_square !== want.square)
                    report_mismatch("entry_square", entry_square, want.square);
                if (fault !== want.fault)
                    report_mismatch("fault", fault, want.fault);
            end
        end
    end

    // Receiver: random stalls, plus long hold-offs on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[square_piece_list_table] ERROR");
        $finish;
    end

    initial
    begin
        occupied_list = '{default: '0};
        slot_of_square = '{default: '0};
        slot_known = '{default: 1'b0};

        plan = '{
            '{spl_pkg::ACT_ADD,    6'd0,  6'd0,  4'd0,  5'd1,  1'b1, 5'd1,  6'd0,  1'b0},
            '{spl_pkg::ACT_ADD,    6'd63, 6'd0,  4'd0,  5'd1,  1'b1, 5'd2,  6'd0,  1'b0},
            '{spl_pkg::ACT_READ,   6'd0,  6'd0,  4'd1,  5'd1,  1'b1, 5'd2,  6'd63, 1'b0},
            '{spl_pkg::ACT_MOVE,   6'd63, 6'd36, 4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_REMOVE, 6'd0,  6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_READ,   6'd0,  6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_REMOVE, 6'd0,  6'd36, 4'd0,  5'd1,  1'b1, 5'd0,  6'd0,  1'b0},
            // Remove on an empty list.
            '{spl_pkg::ACT_REMOVE, 6'd0,  6'd36, 4'd0,  5'd1,  1'b1, 5'd0,  6'd0,  1'b1},
            // The same square added twice.
            '{spl_pkg::ACT_ADD,    6'd42, 6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_ADD,    6'd42, 6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_ADD,    6'd1,  6'd0,  4'd0,  5'd14, 1'b0, 5'd0,  6'd0,  1'b0},
            // Add on a full list.
            '{spl_pkg::ACT_ADD,    6'd7,  6'd0,  4'd0,  5'd1,  1'b1, 5'd16, 6'd0,  1'b1},
            '{spl_pkg::ACT_READ,   6'd0,  6'd0,  4'd15, 5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_MOVE,   6'd42, 6'd63, 4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            // Square 0 was removed earlier, so its map entry is stale.
            '{spl_pkg::ACT_REMOVE, 6'd0,  6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0},
            '{spl_pkg::ACT_READ,   6'd0,  6'd0,  4'd15, 5'd1,  1'b1, 5'd15, 6'd0,  1'b0},
            '{spl_pkg::ACT_READ,   6'd0,  6'd0,  4'd0,  5'd1,  1'b0, 5'd0,  6'd0,  1'b0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = gap_by_phase[0];
        recv_stall_pct = stall_by_phase[0];
        foreach (plan[i])
        begin
            for (int r = 0; r < plan[i].reps; r++)
                send_op(plan[i].act, plan[i].sq_a + SQ_W'(4 * r), plan[i].sq_b,
                        plan[i].idx, plan[i].exact,
                        '{plan[i].want_count, plan[i].want_square, plan[i].want_fault});
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            send_gap_pct = gap_by_phase[phase];
            recv_stall_pct = stall_by_phase[phase];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // The sender keeps offering items while the receiver is held off.
                if (phase == 0 && n == 120)
                    hold_requests++;
                send_random_op();
            end
            if (phase < 2)
                wait_until_drained();
        end

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("[square_piece_list_table] OK");
        else
            $display("[square_piece_list_table] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/spl_pkg.sv
hw/rtl/spl_ctrl.sv
hw/rtl/spl_datapath.sv
hw/rtl/square_piece_list_table.sv
test/square_piece_list_table_tb.sv
